FILE: sv/ptds_pkg.sv
// package for the periodic task dispatch scheduler
// holds request and result codes, sequencer states and table constants
package ptds_pkg;

  localparam int MaxTasks   = 16;
  localparam int SlotW      = 4;
  localparam int PeriodW    = 26;
  localparam int TickW      = 20;
  localparam int PmsW       = 16;
  localparam int ProdW      = 26;
  localparam int MsToUs     = 1000;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_SUSPEND = 3'd2,
    REQ_RESUME  = 3'd3,
    REQ_PERIOD  = 3'd4,
    REQ_SCAN    = 3'd5,
    REQ_RSVD6   = 3'd6,
    REQ_RSVD7   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_DONE     = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_OUT
  } state_t;

  localparam logic [0:0] CfgTick   = 1'b0;
  localparam logic [0:0] CfgEnable = 1'b1;

  // divider control
  typedef struct packed {
    logic start;
    logic [ProdW-1:0] dividend;
    logic [TickW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [ProdW-1:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/ptds_ram.sv
// generic single port ram with registered read
// no package dependency
module ptds_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // registered read, returns the old word on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/ptds_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on ptds_pkg
module ptds_div (
  input  logic                clk,
  input  logic                rst,
  input  ptds_pkg::div_req_t  req,
  output ptds_pkg::div_rsp_t  rsp
);
  import ptds_pkg::*;

  localparam int CntW = $clog2(ProdW + 1);

  logic [TickW:0]   rem;
  logic [ProdW-1:0] quo;
  logic [TickW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [TickW:0]   shifted;
  logic [TickW:0]   diff;

  assign shifted = {rem[TickW-1:0], quo[ProdW-1]};
  assign diff    = shifted - {1'b0, dvs};

  // shift, trial subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= CntW'(ProdW);
      end else if (busy) begin
        if (!diff[TickW]) begin
          rem <= diff;
          quo <= {quo[ProdW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[ProdW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quot: quo};

endmodule

FILE: sv/periodic_task_dispatch_scheduler.sv
// periodic task dispatch scheduler: table of 16 periodic tasks
// add/remove/suspend/resume: the result word goes via ST_OUT to the output register;
// set period on a valid slot with nonzero tick first runs the 26-step serial divider;
// scan reads then evaluates each slot, plus ST_OUT per dispatch and any output wait
// one request at a time; ready returns once the final word is in the output register
// reset: synchronous, clears valid/suspended flags and config to defaults
module periodic_task_dispatch_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [19:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[2:0]
  input  logic [2:0]   s_tuser,
  // task_slot[3:0], func_id[35:4], arg_first[67:36], arg_second[99:68],
  // period_ms[115:100], now_tick[147:116], zero pad
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_kind[1:0]
  output logic [1:0]   m_tuser,
  // out_slot[3:0], out_func_id[35:4], out_arg_first[67:36],
  // out_arg_second[99:68], late_ticks[131:100], zero pad
  output logic [135:0] m_tdata,
  output logic         m_tlast
);
  import ptds_pkg::*;

  // configuration
  logic [TickW-1:0] tick_us;
  logic             tick_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us      <= TickW'(1000);
      tick_enabled <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTick:   tick_us      <= cfg_data;
        CfgEnable: tick_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [2:0]       in_req;
  logic [SlotW-1:0] in_slot;
  logic [31:0]      in_fn, in_a0, in_a1, in_now;
  logic [PmsW-1:0]  in_pms;
  assign in_req  = s_tuser;
  assign in_slot = s_tdata[3:0];
  assign in_fn   = s_tdata[35:4];
  assign in_a0   = s_tdata[67:36];
  assign in_a1   = s_tdata[99:68];
  assign in_pms  = s_tdata[115:100];
  assign in_now  = s_tdata[147:116];

  state_t state, state_next;
  logic [MaxTasks-1:0] valid, susp;
  logic [SlotW-1:0] r_slot, scan_idx;
  logic [31:0] r_now;
  logic        last_slot;
  logic        out_full;
  logic        accept;

  // pending result word, launched into the output register in ST_OUT
  kind_t        pend_kind, pend_kind_next;
  logic [135:0] pend_data, pend_data_next;
  logic         pend_last, pend_last_next;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign last_slot = (scan_idx == SlotW'(MaxTasks - 1));

  // table memories
  logic         ram_we_fn, ram_we_per, ram_we_last;
  logic [SlotW-1:0] ram_addr;
  logic [31:0]  rd_fn, rd_a0, rd_a1, rd_last, wr_last;
  logic [PeriodW-1:0] rd_per, wr_per;

  ptds_ram #(.Width(32), .Depth(MaxTasks)) u_fn (
    .clk(clk), .we(ram_we_fn), .addr(ram_addr), .wdata(in_fn), .rdata(rd_fn));
  ptds_ram #(.Width(32), .Depth(MaxTasks)) u_a0 (
    .clk(clk), .we(ram_we_fn), .addr(ram_addr), .wdata(in_a0), .rdata(rd_a0));
  ptds_ram #(.Width(32), .Depth(MaxTasks)) u_a1 (
    .clk(clk), .we(ram_we_fn), .addr(ram_addr), .wdata(in_a1), .rdata(rd_a1));
  ptds_ram #(.Width(PeriodW), .Depth(MaxTasks)) u_per (
    .clk(clk), .we(ram_we_per), .addr(ram_addr), .wdata(wr_per), .rdata(rd_per));
  ptds_ram #(.Width(32), .Depth(MaxTasks)) u_last (
    .clk(clk), .we(ram_we_last), .addr(ram_addr), .wdata(wr_last),
    .rdata(rd_last));

  // lowest free slot
  logic             has_free;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  logic [ProdW-1:0] prod;
  assign prod = ProdW'(in_pms) * ProdW'(MsToUs);
  assign dreq.start    = accept && in_req == REQ_PERIOD && tick_us != '0
                         && valid[in_slot];
  assign dreq.dividend = prod;
  assign dreq.divisor  = tick_us;

  ptds_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // scan evaluation
  logic [31:0] invl;
  logic        periodic, due, live;
  assign invl     = r_now - rd_last;
  assign periodic = tick_enabled && rd_per != '0;
  assign due      = !periodic || invl >= {6'd0, rd_per};
  assign live     = valid[scan_idx] && !susp[scan_idx];

  // memory port control
  always_comb begin
    ram_we_fn   = 1'b0;
    ram_we_per  = 1'b0;
    ram_we_last = 1'b0;
    ram_addr    = scan_idx;
    wr_per      = '0;
    wr_last     = '0;
    if (state == ST_IDLE && accept && in_req == REQ_ADD && in_fn != '0 && has_free)
    begin
      ram_we_fn = 1'b1; ram_we_per = 1'b1; ram_we_last = 1'b1;
      ram_addr = free_idx;
    end else if (state == ST_IDLE && accept && in_req == REQ_PERIOD &&
                 valid[in_slot] && tick_us == '0) begin
      ram_we_per = 1'b1; ram_addr = in_slot; wr_per = '1;
    end else if (state == ST_DIV) begin
      ram_addr = r_slot; ram_we_per = drsp.done; wr_per = drsp.quot;
    end else if (state == ST_SCAN_EV) begin
      ram_we_last = live && periodic && due;
      wr_last = r_now;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_req == REQ_SCAN) state_next = ST_SCAN_RD;
          else if (dreq.start) state_next = ST_DIV;
          else state_next = ST_OUT;
        end
      end
      ST_DIV:     if (drsp.done) state_next = ST_OUT;
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (live && due) state_next = ST_OUT;
        else if (last_slot) state_next = ST_OUT;
        else state_next = ST_SCAN_RD;
      end
      ST_OUT: begin
        if (!out_full) state_next = pend_last ? ST_IDLE :
                                    (last_slot ? ST_OUT : ST_SCAN_RD);
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // next pending word
  always_comb begin
    pend_kind_next = pend_kind;
    pend_data_next = pend_data;
    pend_last_next = pend_last;
    if (state == ST_IDLE && accept) begin
      pend_kind_next = KIND_ACK;
      pend_data_next = '0;
      pend_last_next = 1'b1;
      case (in_req) inside
        REQ_ADD: begin
          if (in_fn == '0 || !has_free) pend_kind_next = KIND_ERROR;
          else pend_data_next[3:0] = free_idx;
        end
        REQ_REMOVE, REQ_SUSPEND, REQ_RESUME, REQ_PERIOD: pend_data_next[3:0] = in_slot;
        default: ;
      endcase
    end else if (state == ST_SCAN_EV) begin
      if (live && due) begin
        pend_kind_next = KIND_DISPATCH;
        pend_data_next = {4'd0, periodic ? invl - {6'd0, rd_per} : 32'd0,
                          rd_a1, rd_a0, rd_fn, scan_idx};
        pend_last_next = 1'b0;
      end else begin
        pend_kind_next = KIND_DONE;
        pend_data_next = '0;
        pend_last_next = 1'b1;
      end
    end else if (state == ST_OUT && !out_full && !pend_last && last_slot) begin
      // dispatch of the last slot, done word follows
      pend_kind_next = KIND_DONE;
      pend_data_next = '0;
      pend_last_next = 1'b1;
    end
  end

  // state, pending word, table flags, scan pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      susp      <= '0;
      out_full  <= 1'b0;
      m_tlast   <= 1'b0;
      scan_idx  <= '0;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      pend_kind <= pend_kind_next;
      pend_data <= pend_data_next;
      pend_last <= pend_last_next;
      if (m_tvalid && m_tready) out_full <= 1'b0;
      if (state == ST_IDLE && accept) begin
        r_slot   <= in_slot;
        r_now    <= in_now;
        scan_idx <= '0;
        case (in_req)
          REQ_ADD: begin
            if (in_fn != '0 && has_free) begin
              valid[free_idx] <= 1'b1;
              susp[free_idx]  <= 1'b0;
            end
          end
          REQ_REMOVE: begin
            if (valid[in_slot]) begin
              valid[in_slot] <= 1'b0; susp[in_slot] <= 1'b0;
            end
          end
          REQ_SUSPEND: if (valid[in_slot]) susp[in_slot] <= 1'b1;
          REQ_RESUME:  if (valid[in_slot]) susp[in_slot] <= 1'b0;
          default: ;
        endcase
      end
      if (state == ST_SCAN_EV && !(live && due) && !last_slot) scan_idx <= scan_idx + 1'b1;
      if (state == ST_OUT && !out_full) begin
        m_tuser  <= pend_kind;
        m_tdata  <= pend_data;
        m_tlast  <= pend_last;
        out_full <= 1'b1;
        if (!pend_last && !last_slot) scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  assign m_tvalid = out_full;

endmodule

FILE: sv/ptds_checker.sv
// port level checks for the scheduler
// depends on ptds_pkg and binds to periodic_task_dispatch_scheduler
module ptds_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tlast,
  input logic [1:0] m_tuser,
  input logic [135:0] m_tdata
);
  import ptds_pkg::*;

  // output word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output word changed under stall");

  // block is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // a final word is never a dispatch
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser != KIND_DISPATCH)
    else $error("dispatch marked last");

  // a non-final word is a dispatch
  a_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == KIND_DISPATCH)
    else $error("non-dispatch not last");

endmodule

bind periodic_task_dispatch_scheduler ptds_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
  .m_tuser(m_tuser), .m_tdata(m_tdata));
